// ===== rtl/core/rcf_pkg.sv =====
// Shared constants for the reversible circular FIFO: field widths, op and status codes.
package rcf_pkg;

    localparam int DEPTH_DEF   = 1024;
    localparam int VALUE_W     = 32;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;
    localparam int FILL_W      = 10;
    localparam int M_TDATA_W   = 48;
    localparam int M_PAD_W     = M_TDATA_W - VALUE_W - FILL_W;

    localparam logic [OP_W-1:0] OP_ENQ = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQ = 2'd1;
    localparam logic [OP_W-1:0] OP_REV = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

// ===== rtl/core/rcf_ram.sv =====
// Generic simple dual-port RAM, one write port and one registered read port.
module rcf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/reversible_circular_fifo_top.sv =====
// Top level of the reversible circular FIFO: request handling, reversal sequencer, output register.
//
// A circular FIFO of signed 32-bit items holding at most DEPTH-1 of them. Each request on the
// s_ side is an enqueue, a dequeue or a reverse (s_tuser), and each yields exactly one response
// on the m_ side carrying the dequeued value, a status and the fill count after the request.
// Enqueue and dequeue are taken one per clock; a dequeue's value comes from the RAM's registered
// read port the cycle after the request is taken. Reverse answers at once and then stalls the
// input while the sequencer swaps floor(count / 2) pairs of slots through the single read and
// single write port of the item RAM (read low, read high, write low, write high).
// A response held by m_tready low also holds the input.
module reversible_circular_fifo_top #(
    parameter int DEPTH = rcf_pkg::DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rcf_pkg::VALUE_W-1:0]    s_tdata,   // [31:0] value
    input  logic [rcf_pkg::OP_W-1:0]       s_tuser,   // [1:0] op
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rcf_pkg::M_TDATA_W-1:0]  m_tdata,   // [31:0] read_value, [41:32] fill_count
    output logic [rcf_pkg::STATUS_W-1:0]   m_tuser    // [1:0] status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] MAX_COUNT = CW'(DEPTH - 1);

    typedef enum logic [4:0] {
        RV_IDLE  = 5'b00001,
        RV_RD_LO = 5'b00010,
        RV_RD_HI = 5'b00100,
        RV_WR_LO = 5'b01000,
        RV_WR_HI = 5'b10000
    } rev_state_t;

    rev_state_t                    state_reg, state_next;
    logic [AW-1:0]                 head_reg, head_next;
    logic [AW-1:0]                 tail_reg, tail_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [AW-1:0]                 lo_reg, lo_next;
    logic [AW-1:0]                 hi_reg, hi_next;
    logic [CW-1:0]                 pairs_reg, pairs_next;
    logic [rcf_pkg::VALUE_W-1:0]   tmp_reg, tmp_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          out_deq_reg, out_deq_next;
    logic [rcf_pkg::STATUS_W-1:0]  out_status_reg, out_status_next;
    logic [rcf_pkg::FILL_W-1:0]    out_fill_reg, out_fill_next;

    logic                          accept;
    logic                          full;
    logic                          empty;
    logic                          do_enq;
    logic                          do_deq;
    logic                          do_rev;
    logic [AW-1:0]                 tail_prev;

    logic                          ram_wr_en;
    logic [AW-1:0]                 ram_wr_addr;
    logic [rcf_pkg::VALUE_W-1:0]   ram_wr_data;
    logic                          ram_rd_en;
    logic [AW-1:0]                 ram_rd_addr;
    logic [rcf_pkg::VALUE_W-1:0]   ram_rd_data;

    function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
        idx_inc = (i == LAST_IDX) ? '0 : AW'(i + 1'b1);
    endfunction

    function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
        idx_dec = (i == '0) ? LAST_IDX : AW'(i - 1'b1);
    endfunction

    rcf_ram #(
        .WIDTH (rcf_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign s_tready  = (state_reg == RV_IDLE) && (!out_valid_reg || m_tready);
    assign accept    = s_tvalid && s_tready;
    assign full      = (count_reg == MAX_COUNT);
    assign empty     = (count_reg == '0);
    assign do_enq    = accept && (s_tuser == rcf_pkg::OP_ENQ) && !full;
    assign do_deq    = accept && (s_tuser == rcf_pkg::OP_DEQ) && !empty;
    assign do_rev    = accept && (s_tuser == rcf_pkg::OP_REV) && ((count_reg >> 1) != '0);
    assign tail_prev = idx_dec(tail_reg);

    // RAM port steering: requests own the ports when idle, the sequencer otherwise
    always_comb
    begin
        ram_wr_en   = do_enq;
        ram_wr_addr = tail_reg;
        ram_wr_data = s_tdata;
        ram_rd_en   = do_deq;
        ram_rd_addr = head_reg;
        unique case (state_reg)
            RV_IDLE:
            begin
            end
            RV_RD_LO:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = lo_reg;
            end
            RV_RD_HI:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = hi_reg;
            end
            RV_WR_LO:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = lo_reg;
                ram_wr_data = ram_rd_data;
            end
            RV_WR_HI:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = hi_reg;
                ram_wr_data = tmp_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        pairs_next = pairs_reg;
        tmp_next   = tmp_reg;
        unique case (state_reg)
            RV_IDLE:
            begin
                if (do_rev)
                begin
                    state_next = RV_RD_LO;
                    lo_next    = head_reg;
                    hi_next    = tail_prev;
                    pairs_next = count_reg >> 1;
                end
            end
            RV_RD_LO:
            begin
                state_next = RV_RD_HI;
            end
            RV_RD_HI:
            begin
                state_next = RV_WR_LO;
                tmp_next   = ram_rd_data;
            end
            RV_WR_LO:
            begin
                state_next = RV_WR_HI;
            end
            RV_WR_HI:
            begin
                lo_next    = idx_inc(lo_reg);
                hi_next    = idx_dec(hi_reg);
                pairs_next = CW'(pairs_reg - 1'b1);
                state_next = (pairs_reg == CW'(1)) ? RV_IDLE : RV_RD_LO;
            end
            default:
            begin
                state_next = RV_IDLE;
            end
        endcase
    end

    always_comb
    begin
        head_next  = do_deq ? idx_inc(head_reg) : head_reg;
        tail_next  = do_enq ? idx_inc(tail_reg) : tail_reg;
        count_next = count_reg;
        if (do_enq)
        begin
            count_next = CW'(count_reg + 1'b1);
        end
        else if (do_deq)
        begin
            count_next = CW'(count_reg - 1'b1);
        end

        out_status_next = rcf_pkg::ST_OK;
        if (s_tuser == rcf_pkg::OP_ENQ && full)
        begin
            out_status_next = rcf_pkg::ST_FULL;
        end
        else if (s_tuser == rcf_pkg::OP_DEQ && empty)
        begin
            out_status_next = rcf_pkg::ST_EMPTY;
        end
        out_fill_next = rcf_pkg::FILL_W'(count_next);

        out_valid_next = out_valid_reg && !m_tready;
        out_deq_next   = out_deq_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            out_deq_next   = do_deq;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= RV_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            pairs_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_deq_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            pairs_reg     <= pairs_next;
            out_valid_reg <= out_valid_next;
            out_deq_reg   <= out_deq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        tmp_reg <= tmp_next;
        if (accept)
        begin
            out_status_reg <= out_status_next;
            out_fill_reg   <= out_fill_next;
        end
    end

    // dequeued value is read straight off the RAM's read register
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{rcf_pkg::M_PAD_W{1'b0}}, out_fill_reg,
                       (out_deq_reg ? ram_rd_data : {rcf_pkg::VALUE_W{1'b0}})};

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_COUNT)
        else $error("fill count beyond capacity");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (({1'b0, head_reg} + {1'b0, count_reg}) >= (AW + 1)'(DEPTH)
            ? AW'({1'b0, head_reg} + {1'b0, count_reg} - (AW + 1)'(DEPTH))
            : AW'({1'b0, head_reg} + {1'b0, count_reg})) == tail_reg)
        else $error("head, tail and count disagree");

    a_rev_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != RV_IDLE) |-> !s_tready)
        else $error("request taken during reversal");

    a_rdata_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_deq_reg && !m_tready) |=> $stable(ram_rd_data))
        else $error("dequeued value lost while response stalled");

    a_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_wr_en && state_reg == RV_IDLE) |-> (accept && s_tuser == rcf_pkg::OP_ENQ))
        else $error("RAM written without enqueue");
`endif

endmodule
